/* hdl/cpsp_pkg.sv */
// ----------------------------------------------------------------------------
// cpsp_pkg
// Shared widths, defaults and control types of the cascaded position / speed
// PID unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cpsp_pkg;

	localparam int ENCODER_COUNTS_DEF = 8192;
	localparam logic [31:0] SPEED_KD_DEF = 32'd0;
	localparam int FRAC_BITS_DEF = 16;

	// Multiplier operands: unsigned 32-bit gain with a sign bit added, and a
	// signed error term of up to 22 bits.
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 22;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int ACC_W = PROD_W + 2;
	localparam int LIM_W = 15;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD_PROD,
		ACC_ADD_PROD,
		ACC_ADD_EXT,
		ACC_CLAMP
	} acc_op_t;

	typedef struct packed {
		logic    mul_en;
		acc_op_t acc_op;
	} mac_ctl_t;

endpackage

`default_nettype wire

/* hdl/cpsp_mac.sv */
// ----------------------------------------------------------------------------
// cpsp_mac
// Shared multiply-accumulate unit: registered multiplier, accumulator adder
// and symmetric clamp against a limit scaled to the fixed-point format.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsp_mac
	import cpsp_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire mac_ctl_t                  ctl,
	input  wire logic signed [MUL_A_W-1:0] mul_a,
	input  wire logic signed [MUL_B_W-1:0] mul_b,
	input  wire logic signed [ACC_W-1:0]   ext,
	input  wire logic [LIM_W-1:0]          limit,
	output      logic signed [ACC_W-1:0]   acc
);

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  add_opd;
	logic signed [ACC_W-1:0]  add_sum;
	logic signed [ACC_W-1:0]  lim_pos;
	logic signed [ACC_W-1:0]  lim_neg;
	logic signed [ACC_W-1:0]  clamped;

	assign prod_ext = ACC_W'(prod_s1);
	assign add_opd  = (ctl.acc_op == ACC_ADD_EXT) ? ext : prod_ext;
	assign add_sum  = acc_q + add_opd;

	assign lim_pos = signed'(ACC_W'(limit)) <<< FRAC_BITS;
	assign lim_neg = -lim_pos;

	always_comb begin
		if (acc_q > lim_pos) begin
			clamped = lim_pos;
		end else if (acc_q < lim_neg) begin
			clamped = lim_neg;
		end else begin
			clamped = acc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= mul_a * mul_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			case (ctl.acc_op)
				ACC_HOLD:      acc_q <= acc_q;
				ACC_LOAD_PROD: acc_q <= prod_ext;
				ACC_ADD_PROD:  acc_q <= add_sum;
				ACC_ADD_EXT:   acc_q <= add_sum;
				ACC_CLAMP:     acc_q <= clamped;
				default:       acc_q <= acc_q;
			endcase
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

/* hdl/cascade_position_speed_pid_unit.sv */
// ----------------------------------------------------------------------------
// cascade_position_speed_pid_unit
// Cascaded position / speed PID: wrapped angle error into a positional PID
// giving a speed setpoint, then an incremental speed PID into a clamped drive
// accumulator. One shared multiply-accumulate unit under a step sequencer.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  in       | in_valid/in_ready  | op, angle_ref, angle, speed_ref, speed
//  out      | out_valid/out_ready| drive, speed_setpoint
//  cfg      | cfg_we             | cfg_index, cfg_data (write only)
//
//  A cascade tick runs the position loop and then the speed loop; a
//  speed-only tick runs the speed loop alone. Both use the single multiplier,
//  which the sequencer steps through three products per loop plus add, clamp
//  and truncate steps, with an extra accumulate step in the speed loop.
//  in_ready is high only while the sequencer is idle.
//  The result sits in an output register; the sequencer holds in its final
//  step while that register is still full.
//  Reset clears all gains, limits, loop state and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cascade_position_speed_pid_unit
	import cpsp_pkg::*;
#(
	parameter int          ENCODER_COUNTS = ENCODER_COUNTS_DEF,
	parameter logic [31:0] SPEED_KD       = SPEED_KD_DEF,
	parameter int          FRAC_BITS      = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic               op,
	input  wire logic [12:0]        angle_ref,
	input  wire logic [12:0]        angle,
	input  wire logic signed [15:0] speed_ref,
	input  wire logic signed [15:0] speed,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic signed [15:0] drive,
	output      logic signed [15:0] speed_setpoint,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	localparam int ERR_EXT_W = 18;
	localparam logic signed [ERR_EXT_W-1:0] HALF_TURN = ERR_EXT_W'(ENCODER_COUNTS / 2);
	localparam logic signed [ERR_EXT_W-1:0] FULL_TURN = ERR_EXT_W'(ENCODER_COUNTS);
	localparam logic signed [ACC_W-1:0] FRAC_MASK = ACC_W'((64'd1 << FRAC_BITS) - 64'd1);

	localparam logic [2:0] REG_POS_KP        = 3'd0;
	localparam logic [2:0] REG_POS_KI        = 3'd1;
	localparam logic [2:0] REG_POS_KD        = 3'd2;
	localparam logic [2:0] REG_POS_SUM_LIMIT = 3'd3;
	localparam logic [2:0] REG_POS_OUT_LIMIT = 3'd4;
	localparam logic [2:0] REG_SPD_KP        = 3'd5;
	localparam logic [2:0] REG_SPD_KI        = 3'd6;
	localparam logic [2:0] REG_DRIVE_LIMIT   = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRAP,
		ST_PM1,
		ST_PM2,
		ST_PM3,
		ST_PADD,
		ST_PCLMP,
		ST_PSETP,
		ST_SERR,
		ST_SM1,
		ST_SM2,
		ST_SM3,
		ST_SADD,
		ST_SACC,
		ST_SCLMP,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [31:0] pos_kp_q;
	logic [31:0] pos_ki_q;
	logic [31:0] pos_kd_q;
	logic [19:0] pos_sum_limit_q;
	logic [14:0] pos_out_limit_q;
	logic [31:0] spd_kp_q;
	logic [31:0] spd_ki_q;
	logic [14:0] drive_limit_q;

	// latched item
	logic               op_q;
	logic [12:0]        angle_ref_q;
	logic [12:0]        angle_q;
	logic signed [15:0] speed_ref_q;
	logic signed [15:0] speed_q;

	// loop state
	logic signed [13:0]         pos_error_q;
	logic signed [13:0]         pos_prev_error_q;
	logic signed [20:0]         pos_error_sum_q;
	logic signed [16:0]         spd_error_q;
	logic signed [16:0]         spd_prev_error_q;
	logic signed [16:0]         spd_prev2_error_q;
	logic signed [FRAC_BITS+17:0] drive_accum_q;
	logic signed [15:0]         setpoint_q;

	// output register
	logic               out_valid_q;
	logic signed [15:0] out_drive_q;
	logic signed [15:0] out_setpoint_q;

	// datapath
	logic signed [ERR_EXT_W-1:0] ang_diff;
	logic signed [ERR_EXT_W-1:0] ang_wrap;
	logic signed [21:0]          sum_next;
	logic signed [21:0]          sum_lim;
	logic signed [21:0]          sum_clamped;
	logic signed [14:0]          pos_diff;
	logic signed [17:0]          spd_diff;
	logic signed [18:0]          spd_diff2;
	logic signed [16:0]          spd_err_next;
	logic signed [ACC_W-1:0]     acc;
	logic signed [ACC_W-1:0]     acc_rnd;
	logic signed [ACC_W-1:0]     acc_trunc;
	logic signed [15:0]          trunc16;

	mac_ctl_t                    mac_ctl;
	logic signed [MUL_A_W-1:0]   mul_a;
	logic signed [MUL_B_W-1:0]   mul_b;
	logic [LIM_W-1:0]            mac_limit;
	logic signed [ACC_W-1:0]     mac_ext;

	logic in_xfer;
	logic out_load;

	assign in_xfer  = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// angle error wrapped into half a turn
	assign ang_diff = signed'(ERR_EXT_W'(angle_ref_q)) - signed'(ERR_EXT_W'(angle_q));
	always_comb begin
		if (ang_diff > HALF_TURN) begin
			ang_wrap = ang_diff - FULL_TURN;
		end else if (ang_diff < -HALF_TURN) begin
			ang_wrap = ang_diff + FULL_TURN;
		end else begin
			ang_wrap = ang_diff;
		end
	end

	assign sum_next = 22'(pos_error_sum_q) + 22'(signed'(ang_wrap[13:0]));
	assign sum_lim  = signed'({2'b00, pos_sum_limit_q});
	always_comb begin
		if (sum_next > sum_lim) begin
			sum_clamped = sum_lim;
		end else if (sum_next < -sum_lim) begin
			sum_clamped = -sum_lim;
		end else begin
			sum_clamped = sum_next;
		end
	end

	assign pos_diff  = 15'(pos_error_q) - 15'(pos_prev_error_q);
	assign spd_diff  = 18'(spd_error_q) - 18'(spd_prev_error_q);
	assign spd_diff2 = 19'(spd_error_q) - (19'(spd_prev_error_q) <<< 1)
		+ 19'(spd_prev2_error_q);
	assign spd_err_next = op_q ? (17'(setpoint_q) - 17'(speed_q))
		: (17'(speed_ref_q) - 17'(speed_q));

	// truncate toward zero: bias negative values before the shift
	assign acc_rnd   = acc[ACC_W-1] ? (acc + FRAC_MASK) : acc;
	assign acc_trunc = acc_rnd >>> FRAC_BITS;
	assign trunc16   = acc_trunc[15:0];

	// operand selection for the shared unit
	always_comb begin
		mac_ctl.mul_en = 1'b0;
		mac_ctl.acc_op = ACC_HOLD;
		mul_a          = '0;
		mul_b          = '0;
		mac_limit      = drive_limit_q;
		mac_ext        = ACC_W'(drive_accum_q);
		case (state_q)
			ST_PM1: begin
				mac_ctl.mul_en = 1'b1;
				mul_a          = signed'({1'b0, pos_kp_q});
				mul_b          = MUL_B_W'(pos_error_q);
			end
			ST_PM2: begin
				mac_ctl.mul_en = 1'b1;
				mac_ctl.acc_op = ACC_LOAD_PROD;
				mul_a          = signed'({1'b0, pos_ki_q});
				mul_b          = MUL_B_W'(pos_error_sum_q);
			end
			ST_PM3: begin
				mac_ctl.mul_en = 1'b1;
				mac_ctl.acc_op = ACC_ADD_PROD;
				mul_a          = signed'({1'b0, pos_kd_q});
				mul_b          = MUL_B_W'(pos_diff);
			end
			ST_PADD: begin
				mac_ctl.acc_op = ACC_ADD_PROD;
			end
			ST_PCLMP: begin
				mac_ctl.acc_op = ACC_CLAMP;
				mac_limit      = pos_out_limit_q;
			end
			ST_SM1: begin
				mac_ctl.mul_en = 1'b1;
				mul_a          = signed'({1'b0, spd_kp_q});
				mul_b          = MUL_B_W'(spd_diff);
			end
			ST_SM2: begin
				mac_ctl.mul_en = 1'b1;
				mac_ctl.acc_op = ACC_LOAD_PROD;
				mul_a          = signed'({1'b0, spd_ki_q});
				mul_b          = MUL_B_W'(spd_error_q);
			end
			ST_SM3: begin
				mac_ctl.mul_en = 1'b1;
				mac_ctl.acc_op = ACC_ADD_PROD;
				mul_a          = signed'({1'b0, SPEED_KD});
				mul_b          = MUL_B_W'(spd_diff2);
			end
			ST_SADD: begin
				mac_ctl.acc_op = ACC_ADD_PROD;
			end
			ST_SACC: begin
				mac_ctl.acc_op = ACC_ADD_EXT;
			end
			ST_SCLMP: begin
				mac_ctl.acc_op = ACC_CLAMP;
			end
			default: begin
				mac_ctl.acc_op = ACC_HOLD;
			end
		endcase
	end

	cpsp_mac #(
		.FRAC_BITS(FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.mul_a  (mul_a),
		.mul_b  (mul_b),
		.ext    (mac_ext),
		.limit  (mac_limit),
		.acc    (acc)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_kp_q        <= '0;
			pos_ki_q        <= '0;
			pos_kd_q        <= '0;
			pos_sum_limit_q <= '0;
			pos_out_limit_q <= '0;
			spd_kp_q        <= '0;
			spd_ki_q        <= '0;
			drive_limit_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POS_KP:        pos_kp_q        <= cfg_data;
				REG_POS_KI:        pos_ki_q        <= cfg_data;
				REG_POS_KD:        pos_kd_q        <= cfg_data;
				REG_POS_SUM_LIMIT: pos_sum_limit_q <= cfg_data[19:0];
				REG_POS_OUT_LIMIT: pos_out_limit_q <= cfg_data[14:0];
				REG_SPD_KP:        spd_kp_q        <= cfg_data;
				REG_SPD_KI:        spd_ki_q        <= cfg_data;
				REG_DRIVE_LIMIT:   drive_limit_q   <= cfg_data[14:0];
				default:           pos_kp_q        <= pos_kp_q;
			endcase
		end
	end

	// item latch
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q        <= op;
			angle_ref_q <= angle_ref;
			angle_q     <= angle;
			speed_ref_q <= speed_ref;
			speed_q     <= speed;
		end
	end

	// sequencer and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			pos_error_q       <= '0;
			pos_prev_error_q  <= '0;
			pos_error_sum_q   <= '0;
			spd_error_q       <= '0;
			spd_prev_error_q  <= '0;
			spd_prev2_error_q <= '0;
			drive_accum_q     <= '0;
			setpoint_q        <= '0;
			out_valid_q       <= 1'b0;
			out_drive_q       <= '0;
			out_setpoint_q    <= '0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						spd_prev2_error_q <= spd_prev_error_q;
						spd_prev_error_q  <= spd_error_q;
						setpoint_q        <= '0;
						state_q           <= op ? ST_WRAP : ST_SERR;
					end
				end
				ST_WRAP: begin
					pos_prev_error_q <= pos_error_q;
					pos_error_q      <= ang_wrap[13:0];
					pos_error_sum_q  <= sum_clamped[20:0];
					state_q          <= ST_PM1;
				end
				ST_PM1:   state_q <= ST_PM2;
				ST_PM2:   state_q <= ST_PM3;
				ST_PM3:   state_q <= ST_PADD;
				ST_PADD:  state_q <= ST_PCLMP;
				ST_PCLMP: state_q <= ST_PSETP;
				ST_PSETP: begin
					setpoint_q <= trunc16;
					state_q    <= ST_SERR;
				end
				ST_SERR: begin
					spd_error_q <= spd_err_next;
					state_q     <= ST_SM1;
				end
				ST_SM1:   state_q <= ST_SM2;
				ST_SM2:   state_q <= ST_SM3;
				ST_SM3:   state_q <= ST_SADD;
				ST_SADD:  state_q <= ST_SACC;
				ST_SACC:  state_q <= ST_SCLMP;
				ST_SCLMP: state_q <= ST_DONE;
				ST_DONE: begin
					// hold until the output register is free
					if (out_load) begin
						drive_accum_q  <= acc[FRAC_BITS+17:0];
						out_valid_q    <= 1'b1;
						out_drive_q    <= trunc16;
						out_setpoint_q <= setpoint_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign drive          = out_drive_q;
	assign speed_setpoint = out_setpoint_q;

	// assertions
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("accepted a transfer while still working on the last one");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(out_drive_q) && $stable(out_setpoint_q))
		else $error("result changed before it was taken");

	a_drive_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> ($signed({out_drive_q[15], out_drive_q}) <= $signed({2'b00, drive_limit_q}))
			&& ($signed({out_drive_q[15], out_drive_q}) >= -$signed({2'b00, drive_limit_q})))
		else $error("drive result outside the drive limit");

	a_speed_only_zero_setpoint: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !op_q) |=> (out_setpoint_q == 16'sd0))
		else $error("speed-only tick gave a nonzero setpoint");

	a_outer_state_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && !op_q) |=> $stable(pos_error_sum_q) && $stable(pos_error_q))
		else $error("speed-only tick changed the position loop state");

endmodule

`default_nettype wire

/* sim/cpsp_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpsp_checker
// Scoreboard for the cascaded position / speed PID unit. Mirrors register
// writes, runs its own copy of the control loops on every input transfer (the
// position loop on cascade ticks only) and compares each output transfer,
// field by field, against the oldest prediction.
// ----------------------------------------------------------------------------

package cpsp_tb_pkg;

	typedef enum logic [2:0] {
		REG_POS_KP,
		REG_POS_KI,
		REG_POS_KD,
		REG_POS_SUM_LIMIT,
		REG_POS_OUT_LIMIT,
		REG_SPD_KP,
		REG_SPD_KI,
		REG_DRIVE_LIMIT
	} cfg_reg_t;

	localparam logic OP_SPEED_ONLY = 1'b0;
	localparam logic OP_CASCADE    = 1'b1;

endpackage

module cpsp_checker
	import cpsp_pkg::*;
	import cpsp_tb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic               op,
	input  wire logic [12:0]        angle_ref,
	input  wire logic [12:0]        angle,
	input  wire logic signed [15:0] speed_ref,
	input  wire logic signed [15:0] speed,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic signed [15:0] drive,
	input  wire logic signed [15:0] speed_setpoint,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	output int                      errors,
	output int                      pending,
	output int                      checked
);

	localparam int     FRAC      = FRAC_BITS_DEF;
	localparam longint TURN      = ENCODER_COUNTS_DEF;
	localparam longint HALF_TURN = ENCODER_COUNTS_DEF / 2;
	localparam longint SPD_KD    = longint'(SPEED_KD_DEF);

	typedef struct packed {
		logic signed [15:0] drive;
		logic signed [15:0] setpoint;
	} drive_cmd_t;

	drive_cmd_t expected_cmds[$];

	logic [31:0] pos_kp = '0, pos_ki = '0, pos_kd = '0;
	logic [19:0] pos_sum_lim = '0;
	logic [14:0] pos_out_lim = '0;
	logic [31:0] spd_kp = '0, spd_ki = '0;
	logic [14:0] drive_lim = '0;

	logic signed [13:0] pos_err = '0, pos_err_prev = '0;
	logic signed [20:0] pos_err_sum = '0;
	logic signed [16:0] spd_err = '0, spd_err_prev = '0, spd_err_prev2 = '0;
	logic signed [33:0] drive_acc = '0;

	int err_cnt = 0;
	int check_cnt = 0;

	function automatic longint clamp_mag(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// truncate toward zero, not toward minus infinity
	function automatic longint drop_frac(longint v);
		return (v < 0) ? -((-v) >>> FRAC) : (v >>> FRAC);
	endfunction

	task automatic run_control_tick(
		input  logic               cascade,
		input  logic [12:0]        tgt_ang,
		input  logic [12:0]        ang,
		input  logic signed [15:0] tgt_spd,
		input  logic signed [15:0] spd,
		output drive_cmd_t         cmd
	);
		longint e, acc, setp, se, prev, prev2, delta;
		setp = 0;
		spd_err_prev2 = spd_err_prev;
		spd_err_prev  = spd_err;
		prev  = longint'(spd_err_prev);
		prev2 = longint'(spd_err_prev2);
		if (cascade) begin
			e = longint'(tgt_ang) - longint'(ang);
			// take the short way around the turn
			if (e > HALF_TURN)
				e = e - TURN;
			else if (e < -HALF_TURN)
				e = e + TURN;
			pos_err_prev = pos_err;
			pos_err = e[13:0];
			pos_err_sum = 21'(clamp_mag(longint'(pos_err_sum) + e, longint'(pos_sum_lim)));
			acc = longint'(pos_kp) * longint'(pos_err)
				+ longint'(pos_ki) * longint'(pos_err_sum)
				+ longint'(pos_kd) * (longint'(pos_err) - longint'(pos_err_prev));
			acc = clamp_mag(acc, longint'(pos_out_lim) <<< FRAC);
			setp = drop_frac(acc);
			se = setp - longint'(spd);
		end else begin
			se = longint'(tgt_spd) - longint'(spd);
		end
		spd_err = se[16:0];
		delta = longint'(spd_kp) * (se - prev)
			+ longint'(spd_ki) * se
			+ SPD_KD * (se - 2 * prev + prev2);
		drive_acc = 34'(clamp_mag(longint'(drive_acc) + delta, longint'(drive_lim) <<< FRAC));
		cmd.drive    = 16'(drop_frac(longint'(drive_acc)));
		cmd.setpoint = setp[15:0];
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		drive_cmd_t want, got;
		if (!arst_n) begin
			pos_kp = '0;
			pos_ki = '0;
			pos_kd = '0;
			pos_sum_lim = '0;
			pos_out_lim = '0;
			spd_kp = '0;
			spd_ki = '0;
			drive_lim = '0;
			pos_err = '0;
			pos_err_prev = '0;
			pos_err_sum = '0;
			spd_err = '0;
			spd_err_prev = '0;
			spd_err_prev2 = '0;
			drive_acc = '0;
			expected_cmds.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_POS_KP:        pos_kp = cfg_data;
					REG_POS_KI:        pos_ki = cfg_data;
					REG_POS_KD:        pos_kd = cfg_data;
					REG_POS_SUM_LIMIT: pos_sum_lim = cfg_data[19:0];
					REG_POS_OUT_LIMIT: pos_out_lim = cfg_data[14:0];
					REG_SPD_KP:        spd_kp = cfg_data;
					REG_SPD_KI:        spd_ki = cfg_data;
					REG_DRIVE_LIMIT:   drive_lim = cfg_data[14:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got.drive = drive;
				got.setpoint = speed_setpoint;
				if (expected_cmds.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual drive %0d setpoint %0d",
						$time, $signed(got.drive), $signed(got.setpoint));
					err_cnt++;
				end else begin
					want = expected_cmds.pop_front();
					check_cnt++;
					if (got.drive !== want.drive) begin
						$display("%0t: drive mismatch, expected %0d, actual %0d",
							$time, $signed(want.drive), $signed(got.drive));
						err_cnt++;
					end
					if (got.setpoint !== want.setpoint) begin
						$display("%0t: speed_setpoint mismatch, expected %0d, actual %0d",
							$time, $signed(want.setpoint), $signed(got.setpoint));
						err_cnt++;
					end
				end
			end
			if (in_valid && in_ready) begin
				run_control_tick(op, angle_ref, angle, speed_ref, speed, want);
				expected_cmds.push_back(want);
			end
			pending <= expected_cmds.size();
		end
		errors  <= err_cnt;
		checked <= check_cnt;
	end

endmodule

/* sim/cascade_position_speed_pid_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cascade_position_speed_pid_unit_tb
// Drives control ticks and register settings into the PID unit under varying
// input gaps and output back-pressure; the checker beside it predicts every
// drive command and reports the failure count for the verdict.
// ----------------------------------------------------------------------------

module cascade_position_speed_pid_unit_tb
	import cpsp_tb_pkg::*;
();

	localparam int HOLD_CYCLES = 400;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               op = OP_SPEED_ONLY;
	logic [12:0]        angle_ref = '0;
	logic [12:0]        angle = '0;
	logic signed [15:0] speed_ref = '0;
	logic signed [15:0] speed = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] drive;
	logic signed [15:0] speed_setpoint;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	int fail_cnt;
	int pending_cnt;
	int checked_cnt;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	bit hold_go = 1'b0;
	int n_cascade = 0;
	int n_speed = 0;
	int n_settings = 0;

	cascade_position_speed_pid_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.angle_ref      (angle_ref),
		.angle          (angle),
		.speed_ref      (speed_ref),
		.speed          (speed),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.drive          (drive),
		.speed_setpoint (speed_setpoint),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	cpsp_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.angle_ref      (angle_ref),
		.angle          (angle),
		.speed_ref      (speed_ref),
		.speed          (speed),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.drive          (drive),
		.speed_setpoint (speed_setpoint),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.errors         (fail_cnt),
		.pending        (pending_cnt),
		.checked        (checked_cnt)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin : watchdog
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	// output side: random stalls, plus one long hold-off on request
	initial begin : receiver
		bit hold_taken;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_taken) begin
				hold_taken = 1'b1;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready = ($urandom_range(99) >= sink_stall_pct);
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic load_gains(
		input logic [31:0] p_kp, input logic [31:0] p_ki, input logic [31:0] p_kd,
		input logic [31:0] sum_lim, input logic [31:0] out_lim,
		input logic [31:0] s_kp, input logic [31:0] s_ki, input logic [31:0] d_lim
	);
		write_reg(REG_POS_KP, p_kp);
		write_reg(REG_POS_KI, p_ki);
		write_reg(REG_POS_KD, p_kd);
		write_reg(REG_POS_SUM_LIMIT, sum_lim);
		write_reg(REG_POS_OUT_LIMIT, out_lim);
		write_reg(REG_SPD_KP, s_kp);
		write_reg(REG_SPD_KI, s_ki);
		write_reg(REG_DRIVE_LIMIT, d_lim);
		n_settings++;
	endtask

	task automatic load_random_gains();
		logic [31:0] sum_lim, out_lim, d_lim;
		sum_lim = $urandom_range(1048575) >> $urandom_range(10, 0);
		out_lim = $urandom_range(32767);
		d_lim = $urandom_range(32767);
		load_gains($urandom >> $urandom_range(31, 6), $urandom >> $urandom_range(31, 8),
			$urandom >> $urandom_range(31, 6), sum_lim, out_lim,
			$urandom >> $urandom_range(31, 6), $urandom >> $urandom_range(31, 8), d_lim);
	endtask

	// hold the input until every transfer has come back out
	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending_cnt != 0)
			@(negedge clk);
	endtask

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic offer_tick(
		input logic o, input logic [12:0] ta, input logic [12:0] a,
		input logic signed [15:0] ts, input logic signed [15:0] s
	);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		op = o;
		angle_ref = ta;
		angle = a;
		speed_ref = ts;
		speed = s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		if (o == OP_CASCADE)
			n_cascade++;
		else
			n_speed++;
	endtask

	task automatic offer_random_tick();
		logic o;
		logic [12:0] ta, a;
		logic signed [15:0] ts, s;
		int v;
		o = ($urandom_range(99) < 70) ? OP_CASCADE : OP_SPEED_ONLY;
		ta = 13'($urandom_range(8191));
		// mostly track near the target, crossing the wrap point now and then
		if ($urandom_range(3) == 0)
			a = 13'($urandom_range(8191));
		else
			a = 13'(ta + $urandom_range(400) - 200);
		if ($urandom_range(3) == 0) begin
			ts = 16'($urandom);
			s = 16'($urandom);
		end else begin
			v = int'($urandom_range(2000)) - 1000;
			ts = v[15:0];
			v = int'($urandom_range(2000)) - 1000;
			s = v[15:0];
		end
		offer_tick(o, ta, a, ts, s);
	endtask

	initial begin : stimulus
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset values: every limit is zero, so both outputs stay zero
		offer_tick(OP_CASCADE, 13'd8191, 13'd0, 16'sd32767, 16'sd32767);
		offer_tick(OP_SPEED_ONLY, 13'd0, 13'd0, -16'sd32768, 16'sd32767);
		wait_drained();

		load_gains(32'h0002_0000, 32'h0000_0800, 32'h0000_8000, 32'd20000, 32'd3000,
			32'h0000_4000, 32'h0000_1000, 32'd16000);
		offer_tick(OP_CASCADE, 13'd0, 13'd8191, 16'sd0, 16'sd0);
		offer_tick(OP_CASCADE, 13'd8191, 13'd0, 16'sd0, 16'sd0);
		offer_tick(OP_CASCADE, 13'd4096, 13'd0, 16'sd0, 16'sd100);
		offer_tick(OP_CASCADE, 13'd0, 13'd4096, 16'sd0, -16'sd100);
		offer_tick(OP_CASCADE, 13'd4097, 13'd0, 16'sd0, 16'sd0);
		offer_tick(OP_CASCADE, 13'd0, 13'd4097, 16'sd0, 16'sd0);
		offer_tick(OP_CASCADE, 13'd100, 13'd100, 16'sd0, -16'sd32768);
		// speed-only ticks must leave the outer loop state alone
		offer_tick(OP_SPEED_ONLY, 13'd8191, 13'd0, 16'sd32767, -16'sd32768);
		offer_tick(OP_SPEED_ONLY, 13'd0, 13'd8191, -16'sd32768, 16'sd32767);
		offer_tick(OP_CASCADE, 13'd100, 13'd100, 16'sd0, 16'sd0);
		repeat (6)
			offer_tick(OP_CASCADE, 13'd2000, 13'd6000, 16'sd0, 16'sd0);
		wait_drained();

		load_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1048575, 32'd32767,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd32767);
		offer_tick(OP_CASCADE, 13'd4096, 13'd0, 16'sd0, -16'sd32768);
		offer_tick(OP_SPEED_ONLY, 13'd0, 13'd0, 16'sd32767, -16'sd32768);
		offer_tick(OP_CASCADE, 13'd0, 13'd4096, 16'sd0, 16'sd32767);
		wait_drained();

		// nonzero gains with zero limits
		load_gains(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0,
			32'h0001_0000, 32'h0001_0000, 32'd0);
		offer_tick(OP_CASCADE, 13'd1234, 13'd50, 16'sd0, 16'sd500);
		offer_tick(OP_SPEED_ONLY, 13'd0, 13'd0, 16'sd1000, -16'sd1000);
		wait_drained();

		// back the block up behind a long output stall
		load_gains(32'h0002_0000, 32'h0000_0800, 32'h0000_8000, 32'd20000, 32'd3000,
			32'h0000_4000, 32'h0000_1000, 32'd16000);
		hold_go = 1'b1;
		repeat (40)
			offer_random_tick();
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 57; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 57; end
				default: begin src_idle_pct = 35; sink_stall_pct = 35; end
			endcase
			for (int k = 0; k < 5; k++) begin
				if (k == 0 && p == 1)
					load_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1048575,
						32'd32767, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd32767);
				else if (k == 0 && p == 3)
					load_gains(32'h0000_8000, 32'h0000_0100, 32'h0000_4000, 32'd1, 32'd1,
						32'h0000_2000, 32'h0000_0800, 32'd1);
				else
					load_random_gains();
				repeat (50)
					offer_random_tick();
				wait_drained();
			end
		end

		wait_drained();
		repeat (32) @(negedge clk);
		$display("run covered %0d cascade and %0d speed-only ticks over %0d register settings",
			n_cascade, n_speed, n_settings);
		$display("%0d results compared, with gaps, back-pressure and a long output hold-off",
			checked_cnt);
		if (fail_cnt == 0 && pending_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* files.f */
hdl/cpsp_pkg.sv
hdl/cpsp_mac.sv
hdl/cascade_position_speed_pid_unit.sv
sim/cpsp_checker.sv
sim/cascade_position_speed_pid_unit_tb.sv
